// File: design/multi_pattern_string_matcher_defines.svh
// assertion macros used by the matcher engine module
`ifndef MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define MPSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mpsm assertion failed");
`define MPSM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mpsm forbidden condition");
`else
`define MPSM_ASSERT(lbl, prop)
`define MPSM_NEVER(lbl, cond)
`endif

`endif

// File: design/mpsm_pkg.sv
package mpsm_pkg;

  localparam logic [1:0] K_CLEAR   = 2'd0;
  localparam logic [1:0] K_PATTERN = 2'd1;
  localparam logic [1:0] K_BUILD   = 2'd2;
  localparam logic [1:0] K_TEXT    = 2'd3;

  localparam logic [1:0] ST_MATCH  = 2'd0;
  localparam logic [1:0] ST_STORED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_LONG   = 2'd3;
  // pending load error: same codes, zero meaning none
  localparam logic [1:0] ERR_NONE  = 2'd0;

  localparam int RESULT_CAP = 16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       pattern_end;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] pattern_id;
    logic       last;
  } res_t;

endpackage

// File: design/multi_pattern_string_matcher.sv
// channel   dir  transfer when          payload
// in_       in   in_valid & !in_stall   in_kind, in_byte_value, in_pattern_end
// out_      out  out_valid & !out_stall out_status, out_pattern_id, out_last
//
// one item is worked at a time; a two-entry input queue decouples acceptance
// clear: done in idle as it is taken; pattern byte: goto lookup + key check
// text byte: a lookup per failure link, a visit per node, the end node included
// build: nodes x MAX_PATTERN_LEN depth passes, each matched node walks its
// parent's failure chain; no clearing pass after reset, entries are
// validated by the node count and each node's stored parent and byte
module multi_pattern_string_matcher #(
  parameter int NODES           = 256,
  parameter int ALPHABET        = 256,
  parameter int MAX_PATTERN_LEN = 16,
  parameter int MAX_PATTERNS    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_byte_value,
  input  logic       in_pattern_end,
  output logic       in_stall,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [5:0] out_pattern_id,
  output logic       out_last,
  input  logic       out_stall
);

  logic            item_valid;
  logic            item_pop;
  mpsm_pkg::item_t item;
  logic            out_free;
  logic            res_push;
  mpsm_pkg::res_t  res;
  logic            out_valid_r;
  mpsm_pkg::res_t  out_r;

  mpsm_front #(.ALPHABET(ALPHABET)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_kind(in_kind), .in_byte_value(in_byte_value),
    .in_pattern_end(in_pattern_end), .in_stall(in_stall),
    .item_valid(item_valid), .item(item), .item_pop(item_pop)
  );

  mpsm_engine #(
    .NODES(NODES), .ALPHABET(ALPHABET),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN), .MAX_PATTERNS(MAX_PATTERNS)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(item_valid), .item(item), .item_pop(item_pop),
    .out_free(out_free), .res_push(res_push), .res(res)
  );

  // output register, refilled in the cycle of its transfer
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_pattern_id = out_r.pattern_id;
  assign out_last       = out_r.last;

endmodule

// File: design/mpsm_ram.sv
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/mpsm_front.sv
module mpsm_front #(
  parameter int ALPHABET = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_kind,
  input  logic [7:0]          in_byte_value,
  input  logic                in_pattern_end,
  output logic                in_stall,
  output logic                item_valid,
  output mpsm_pkg::item_t     item,
  input  logic                item_pop
);

  mpsm_pkg::item_t q_r [2];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  mpsm_pkg::item_t in_item;

  // byte folded into the alphabet by restoring subtraction
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [15:0] r;
    r = {8'd0, b};
    for (int i = 7; i >= 0; i--) begin
      if (r >= (16'(ALPHABET) << i)) begin
        r = r - (16'(ALPHABET) << i);
      end
    end
    return r[7:0];
  endfunction

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];

  always_comb begin
    in_item.kind        = in_kind;
    in_item.byte_value  = fold_byte(in_byte_value);
    in_item.pattern_end = in_pattern_end;
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = item_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(item_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
  end

endmodule

// File: design/mpsm_engine.sv
`include "multi_pattern_string_matcher_defines.svh"

module mpsm_engine #(
  parameter int NODES           = 256,
  parameter int ALPHABET        = 256,
  parameter int MAX_PATTERN_LEN = 16,
  parameter int MAX_PATTERNS    = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  mpsm_pkg::item_t item,
  output logic            item_pop,
  input  logic            out_free,
  output logic            res_push,
  output mpsm_pkg::res_t  res
);

  localparam int NW = $clog2(NODES);
  localparam int AW = $clog2(ALPHABET);
  localparam int GD = NODES * ALPHABET;
  localparam int GW = $clog2(GD);
  localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int PW = $clog2(MAX_PATTERNS + 1);
  localparam int KW = NW + AW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LD    = 5'd1;
  localparam logic [4:0] S_LK0   = 5'd2;
  localparam logic [4:0] S_LK1   = 5'd3;
  localparam logic [4:0] S_LK2   = 5'd4;
  localparam logic [4:0] S_LK3   = 5'd5;
  localparam logic [4:0] S_WF0   = 5'd6;
  localparam logic [4:0] S_WF1   = 5'd7;
  localparam logic [4:0] S_SP0   = 5'd8;
  localparam logic [4:0] S_SP1   = 5'd9;
  localparam logic [4:0] S_FIN   = 5'd10;
  localparam logic [4:0] S_LEND  = 5'd11;
  localparam logic [4:0] S_BR0   = 5'd12;
  localparam logic [4:0] S_BR1   = 5'd13;
  localparam logic [4:0] S_BF0   = 5'd14;
  localparam logic [4:0] S_BF1   = 5'd15;
  localparam logic [4:0] S_BP0   = 5'd16;
  localparam logic [4:0] S_BP1   = 5'd17;
  localparam logic [4:0] S_BNEXT = 5'd18;

  logic [4:0]    state_r, state_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [NW-1:0] icur_r, icur_nxt;
  logic [LW-1:0] ilen_r, ilen_nxt;
  logic [1:0]    ierr_r, ierr_nxt;
  logic [NW:0]   ncount_r, ncount_nxt;
  logic [PW-1:0] pcount_r, pcount_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [AW-1:0] c_r, c_nxt;
  logic          end_r, end_nxt;
  logic [NW-1:0] wn_r, wn_nxt;
  logic [AW-1:0] wc_r, wc_nxt;
  logic [NW-1:0] gv_r, gv_nxt;
  logic [NW-1:0] fr_r, fr_nxt;
  logic [NW-1:0] pn_r, pn_nxt;
  logic [NW-1:0] bv_r, bv_nxt;
  logic [LW-1:0] d_r, d_nxt;
  logic [4:0]    k_r, k_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [5:0]    pend_id_r, pend_id_nxt;

  // memory ports
  logic          goto_we;
  logic [GW-1:0] goto_wa, goto_ra;
  logic [NW-1:0] goto_wd, goto_rd;
  logic          key_we;
  logic [NW-1:0] key_wa, key_ra;
  logic [KW-1:0] key_wd, key_rd;
  logic          fail_we, dict_we, pat_we, dep_we;
  logic [NW-1:0] fail_wa, dict_wa, pat_wa;
  logic [NW-1:0] fail_wd, dict_wd, fail_rd, dict_rd;
  logic [PW-1:0] pat_wd, pat_rd;
  logic [LW-1:0] dep_wd, dep_rd;

  logic [NW-1:0] fail_q, dict_q;
  logic [PW-1:0] pat_q;
  logic          hit;
  logic [NW-1:0] wres;
  logic          produce;
  logic [4:0]    k_add;
  logic [1:0]    fin_err;
  logic          clear_go;

  mpsm_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
    .clk(clk), .we(goto_we), .waddr(goto_wa), .wdata(goto_wd),
    .raddr(goto_ra), .rdata(goto_rd)
  );
  // parent node and byte of each node, validates goto entries of this epoch
  mpsm_ram #(.WIDTH(KW), .DEPTH(NODES)) u_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
    .raddr(key_ra), .rdata(key_rd)
  );
  mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
    .clk(clk), .we(fail_we), .waddr(fail_wa), .wdata(fail_wd),
    .raddr(fr_r), .rdata(fail_rd)
  );
  mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_dict (
    .clk(clk), .we(dict_we), .waddr(dict_wa), .wdata(dict_wd),
    .raddr(pn_r), .rdata(dict_rd)
  );
  mpsm_ram #(.WIDTH(PW), .DEPTH(NODES)) u_pat (
    .clk(clk), .we(pat_we), .waddr(pat_wa), .wdata(pat_wd),
    .raddr(pn_r), .rdata(pat_rd)
  );
  mpsm_ram #(.WIDTH(LW), .DEPTH(NODES)) u_depth (
    .clk(clk), .we(dep_we), .waddr(NW'(ncount_r)), .wdata(dep_wd),
    .raddr(bv_r), .rdata(dep_rd)
  );

  assign goto_ra = GW'(wn_r) * GW'(ALPHABET) + GW'(wc_r);
  assign key_ra  = (state_r == S_BR0 || state_r == S_BR1) ? bv_r : gv_r;
  // the root's entries are never written: force them to zero
  assign fail_q  = (fr_r == '0) ? '0 : fail_rd;
  assign dict_q  = (pn_r == '0) ? '0 : dict_rd;
  assign pat_q   = (pn_r == '0) ? '0 : pat_rd;
  assign hit     = (gv_r != '0) && ({1'b0, gv_r} < ncount_r) && (key_rd == {wn_r, wc_r});
  assign wres    = hit ? gv_r : '0;
  assign produce = (pn_r != '0) && (pat_q != '0);
  assign k_add   = k_r + 5'(produce);
  assign fin_err = (ierr_r != mpsm_pkg::ERR_NONE) ? ierr_r :
                   ((pcount_r >= PW'(MAX_PATTERNS)) ? mpsm_pkg::ST_LONG : mpsm_pkg::ERR_NONE);
  assign clear_go = (state_r == S_IDLE) && item_valid && (item.kind == mpsm_pkg::K_CLEAR);

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    icur_nxt    = icur_r;
    ilen_nxt    = ilen_r;
    ierr_nxt    = ierr_r;
    ncount_nxt  = ncount_r;
    pcount_nxt  = pcount_r;
    kind_nxt    = kind_r;
    c_nxt       = c_r;
    end_nxt     = end_r;
    wn_nxt      = wn_r;
    wc_nxt      = wc_r;
    gv_nxt      = gv_r;
    fr_nxt      = fr_r;
    pn_nxt      = pn_r;
    bv_nxt      = bv_r;
    d_nxt       = d_r;
    k_nxt       = k_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    item_pop    = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    goto_we     = 1'b0;
    goto_wa     = GW'(icur_r) * GW'(ALPHABET) + GW'(c_r);
    goto_wd     = NW'(ncount_r);
    key_we      = 1'b0;
    key_wa      = NW'(ncount_r);
    key_wd      = {icur_r, c_r};
    fail_we     = 1'b0;
    fail_wa     = NW'(ncount_r);
    fail_wd     = '0;
    dict_we     = 1'b0;
    dict_wa     = NW'(ncount_r);
    dict_wd     = '0;
    pat_we      = 1'b0;
    pat_wa      = NW'(ncount_r);
    pat_wd      = '0;
    dep_we      = 1'b0;
    dep_wd      = ilen_r + LW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          kind_nxt = item.kind;
          c_nxt    = AW'(item.byte_value);
          end_nxt  = item.pattern_end;
          unique case (item.kind)
            mpsm_pkg::K_CLEAR: begin
              cur_nxt    = '0;
              icur_nxt   = '0;
              ilen_nxt   = '0;
              ierr_nxt   = mpsm_pkg::ERR_NONE;
              ncount_nxt = (NW+1)'(1);
              pcount_nxt = '0;
            end
            mpsm_pkg::K_PATTERN: state_nxt = S_LD;
            mpsm_pkg::K_BUILD: begin
              cur_nxt   = '0;
              d_nxt     = LW'(1);
              bv_nxt    = NW'(1);
              state_nxt = (ncount_r == (NW+1)'(1)) ? S_IDLE : S_BR0;
            end
            mpsm_pkg::K_TEXT: begin
              wn_nxt    = cur_r;
              wc_nxt    = AW'(item.byte_value);
              state_nxt = S_LK0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD: begin
        if (ierr_r != mpsm_pkg::ERR_NONE) begin
          state_nxt = S_LEND;
        end else if (ilen_r >= LW'(MAX_PATTERN_LEN)) begin
          ierr_nxt  = mpsm_pkg::ST_LONG;
          state_nxt = S_LEND;
        end else begin
          wn_nxt    = icur_r;
          wc_nxt    = c_r;
          state_nxt = S_LK0;
        end
      end
      S_LK0: state_nxt = S_LK1;
      S_LK1: begin
        gv_nxt    = goto_rd;
        state_nxt = S_LK2;
      end
      S_LK2: state_nxt = S_LK3;
      S_LK3: begin
        if (kind_r == mpsm_pkg::K_PATTERN) begin
          state_nxt = S_LEND;
          if (hit) begin
            icur_nxt = gv_r;
            ilen_nxt = ilen_r + LW'(1);
          end else if (ncount_r == (NW+1)'(NODES)) begin
            ierr_nxt = mpsm_pkg::ST_FULL;
          end else begin
            // new node: edge, parent key, depth and cleared per-node entries
            goto_we    = 1'b1;
            key_we     = 1'b1;
            fail_we    = 1'b1;
            dict_we    = 1'b1;
            pat_we     = 1'b1;
            dep_we     = 1'b1;
            icur_nxt   = NW'(ncount_r);
            ncount_nxt = ncount_r + (NW+1)'(1);
            ilen_nxt   = ilen_r + LW'(1);
          end
        end else if (hit || wn_r == '0) begin
          if (kind_r == mpsm_pkg::K_TEXT) begin
            cur_nxt   = wres;
            pn_nxt    = wres;
            k_nxt     = '0;
            state_nxt = S_SP0;
          end else begin
            pn_nxt    = (wres == bv_r) ? '0 : wres;
            state_nxt = S_BP0;
          end
        end else begin
          fr_nxt    = wn_r;
          state_nxt = S_WF0;
        end
      end
      S_WF0: state_nxt = S_WF1;
      S_WF1: begin
        wn_nxt    = fail_q;
        state_nxt = S_LK0;
      end
      S_SP0: state_nxt = S_SP1;
      S_SP1: begin
        // a new match first pushes out the one held back
        if (!(produce && pend_v_r && !out_free)) begin
          if (produce) begin
            if (pend_v_r) begin
              res_push          = 1'b1;
              res.status        = mpsm_pkg::ST_MATCH;
              res.pattern_id    = pend_id_r;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = 6'(pat_q - PW'(1));
          end
          k_nxt = k_add;
          if (dict_q != '0 && k_add < 5'(mpsm_pkg::RESULT_CAP)) begin
            pn_nxt    = dict_q;
            state_nxt = S_SP0;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          res_push       = 1'b1;
          res.status     = mpsm_pkg::ST_MATCH;
          res.pattern_id = pend_id_r;
          res.last       = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_LEND: begin
        if (!end_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          res_push   = 1'b1;
          res.status = (fin_err == mpsm_pkg::ERR_NONE) ? mpsm_pkg::ST_STORED : fin_err;
          res.last   = 1'b1;
          if (fin_err == mpsm_pkg::ERR_NONE) begin
            res.pattern_id = 6'(pcount_r);
            pat_we         = 1'b1;
            pat_wa         = icur_r;
            pat_wd         = pcount_r + PW'(1);
            pcount_nxt     = pcount_r + PW'(1);
          end
          icur_nxt  = '0;
          ilen_nxt  = '0;
          ierr_nxt  = mpsm_pkg::ERR_NONE;
          state_nxt = S_IDLE;
        end
      end
      S_BR0: state_nxt = S_BR1;
      S_BR1: begin
        if (dep_rd == d_r) begin
          wc_nxt = key_rd[AW-1:0];
          if (key_rd[KW-1:AW] == '0) begin
            pn_nxt    = '0;
            state_nxt = S_BP0;
          end else begin
            fr_nxt    = key_rd[KW-1:AW];
            state_nxt = S_BF0;
          end
        end else begin
          state_nxt = S_BNEXT;
        end
      end
      S_BF0: state_nxt = S_BF1;
      S_BF1: begin
        wn_nxt    = fail_q;
        state_nxt = S_LK0;
      end
      S_BP0: state_nxt = S_BP1;
      S_BP1: begin
        fail_we   = 1'b1;
        fail_wa   = bv_r;
        fail_wd   = pn_r;
        dict_we   = 1'b1;
        dict_wa   = bv_r;
        dict_wd   = (pat_q != '0) ? pn_r : dict_q;
        state_nxt = S_BNEXT;
      end
      S_BNEXT: begin
        if ({1'b0, bv_r} == ncount_r - (NW+1)'(1)) begin
          if (d_r == LW'(MAX_PATTERN_LEN)) begin
            state_nxt = S_IDLE;
          end else begin
            d_nxt     = d_r + LW'(1);
            bv_nxt    = NW'(1);
            state_nxt = S_BR0;
          end
        end else begin
          bv_nxt    = bv_r + NW'(1);
          state_nxt = S_BR0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_r    <= '0;
      icur_r   <= '0;
      ilen_r   <= '0;
      ierr_r   <= mpsm_pkg::ERR_NONE;
      ncount_r <= (NW+1)'(1);
      pcount_r <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      icur_r   <= icur_nxt;
      ilen_r   <= ilen_nxt;
      ierr_r   <= ierr_nxt;
      ncount_r <= ncount_nxt;
      pcount_r <= pcount_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    c_r       <= c_nxt;
    end_r     <= end_nxt;
    wn_r      <= wn_nxt;
    wc_r      <= wc_nxt;
    gv_r      <= gv_nxt;
    fr_r      <= fr_nxt;
    pn_r      <= pn_nxt;
    bv_r      <= bv_nxt;
    d_r       <= d_nxt;
    k_r       <= k_nxt;
    pend_id_r <= pend_id_nxt;
  end

  `MPSM_ASSERT(a_push_free, res_push |-> out_free)
  `MPSM_ASSERT(a_clear_resets, clear_go |=> (ncount_r == (NW+1)'(1) && pcount_r == '0))
  `MPSM_ASSERT(a_idle_no_pending, (state_r == S_IDLE) |-> !pend_v_r)
  `MPSM_NEVER(a_count_range, ncount_r == '0 || ncount_r > (NW+1)'(NODES))
  `MPSM_NEVER(a_len_range, ilen_r > LW'(MAX_PATTERN_LEN))

endmodule
